[hdl/bcddm_pkg.sv]
// Shared types and constants for the multiplexed BCD display block.
// Used by the converter stages, the digit serializer and the top level.
`default_nettype none

package bcddm_pkg;

  localparam int BIN_W       = 32;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
  localparam int NUM_STAGES  = 4;
  localparam int STEPS       = BIN_W / NUM_STAGES;
  localparam int CNT_W       = 4;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] COUNT_MIN   = CNT_W'(1);

  localparam logic [0:0] REG_DIGIT_COUNT = 1'b0;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } dd_word_t;

endpackage

`default_nettype wire

[hdl/bcddm_dabble_stage.sv]
// One pipeline stage of the shift-and-add-3 binary to BCD converter.
// Depends on bcddm_pkg for the stage word type and step count.
`default_nettype none

module bcddm_dabble_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bcddm_pkg::dd_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bcddm_pkg::dd_word_t    out_word
);
  import bcddm_pkg::*;

  logic     valid_r;
  dd_word_t word_r;
  dd_word_t word_nxt;

  always_comb begin
    dd_word_t w;
    w = in_word;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (w.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
          w.bcd[d*DIGIT_W +: DIGIT_W] = w.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
        end
      end
      w.bcd = {w.bcd[BCD_W-2:0], w.bin[BIN_W-1]};
      w.bin = {w.bin[BIN_W-2:0], 1'b0};
    end
    word_nxt = w;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/bcddm_serializer.sv]
// Digit serializer: emits one BCD digit per request, least significant first.
// Depends on bcddm_pkg for digit widths and the digit vector size.
`default_nettype none

module bcddm_serializer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [bcddm_pkg::CNT_W-1:0]       eff_count,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bcddm_pkg::BCD_W-1:0]       in_bcd,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bcddm_pkg::CNT_W-1:0]            out_digit_position,
  output logic [bcddm_pkg::DIGIT_W-1:0]          out_bcd_digit,
  output logic                                   out_last_digit
);
  import bcddm_pkg::*;

  logic               busy_r,    busy_nxt;
  logic [BCD_W-1:0]   digits_r,  digits_nxt;
  logic [CNT_W-1:0]   pos_r,     pos_nxt;
  logic [CNT_W-1:0]   lastpos_r, lastpos_nxt;
  logic               is_last;

  assign is_last  = (pos_r == lastpos_r);
  assign in_ready = !busy_r || (out_ready && is_last);

  always_comb begin
    busy_nxt    = busy_r;
    digits_nxt  = digits_r;
    pos_nxt     = pos_r;
    lastpos_nxt = lastpos_r;
    if (in_valid && in_ready) begin
      busy_nxt    = 1'b1;
      digits_nxt  = in_bcd;
      pos_nxt     = '0;
      lastpos_nxt = eff_count - COUNT_MIN;
    end else if (busy_r && out_ready) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        digits_nxt = {DIGIT_W'(0), digits_r[BCD_W-1:DIGIT_W]};
        pos_nxt    = pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r  <= digits_nxt;
    pos_r     <= pos_nxt;
    lastpos_r <= lastpos_nxt;
  end

  assign out_valid          = busy_r;
  assign out_digit_position = pos_r;
  assign out_bcd_digit      = digits_r[DIGIT_W-1:0];
  assign out_last_digit     = is_last;

endmodule

`default_nettype wire

[hdl/bcd_digit_display_mux.sv]
// Top level of the multiplexed BCD display driver: APB register, converter pipeline
// and digit serializer. Depends on bcddm_pkg, bcddm_dabble_stage, bcddm_serializer.
//
//   channel | ports                                    | moves
//   in      | in_valid, in_ready, in_value             | one 32-bit value per request
//   out     | out_valid, out_ready, out_digit_position,| one digit per request
//           | out_bcd_digit, out_last_digit            |
//   cfg     | psel, penable, pwrite, paddr, pwdata,    | digit_count at address 0
//           | prdata, pready                           |
//
// Each value yields max(1, min(digit_count, 10)) digits; the serializer port,
// one digit per cycle while out_ready is high, sets the rate. Conversion runs
// through four register stages of eight shift steps each, then the serializer
// register, which presents the first digit of an accepted request.
// Reset is synchronous and sets digit_count to 3.
// A stall on out holds each stage; no request is lost or repeated.
`default_nettype none

module bcd_digit_display_mux (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bcddm_pkg::BIN_W-1:0]         in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [bcddm_pkg::CNT_W-1:0]              out_digit_position,
  output logic [bcddm_pkg::DIGIT_W-1:0]            out_bcd_digit,
  output logic                                     out_last_digit,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bcddm_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bcddm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bcddm_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                     pready
);
  import bcddm_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] eff_count;
  logic [0:0]       reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (psel && penable && pwrite && reg_index == REG_DIGIT_COUNT) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_DIGIT_COUNT) begin
      prdata[CNT_W-1:0] = count_r;
    end
  end

  always_comb begin
    if (count_r < COUNT_MIN) begin
      eff_count = COUNT_MIN;
    end else if (count_r > COUNT_MAX) begin
      eff_count = COUNT_MAX;
    end else begin
      eff_count = count_r;
    end
  end

  logic     stg_valid [NUM_STAGES+1];
  logic     stg_ready [NUM_STAGES+1];
  dd_word_t stg_word  [NUM_STAGES+1];

  assign stg_valid[0]    = in_valid;
  assign in_ready        = stg_ready[0];
  assign stg_word[0].bin = in_value;
  assign stg_word[0].bcd = '0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    bcddm_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_word   (stg_word[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_word  (stg_word[g+1])
    );
  end

  bcddm_serializer u_ser (
    .clk                (clk),
    .rst_n              (rst_n),
    .eff_count          (eff_count),
    .in_valid           (stg_valid[NUM_STAGES]),
    .in_ready           (stg_ready[NUM_STAGES]),
    .in_bcd             (stg_word[NUM_STAGES].bcd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_digit_position (out_digit_position),
    .out_bcd_digit      (out_bcd_digit),
    .out_last_digit     (out_last_digit)
  );

endmodule

`default_nettype wire
